FILE: hdl/largest_blob_size_finder_defines.svh
// ----------------------------------------------------------------------------
// Largest blob size finder: assertion macros
// Concurrent checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LARGEST_BLOB_SIZE_FINDER_DEFINES_SVH
`define LARGEST_BLOB_SIZE_FINDER_DEFINES_SVH

// Same-cycle implication
`define LBSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LBSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lbsf_pkg.sv
// ----------------------------------------------------------------------------
// lbsf_pkg
// Shared constants, direction codes and side clamp for the blob size finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbsf_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
  // row / col coordinate width
  localparam int ROW_W      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  // {row, col} address into image and stack memories
  localparam int ADDR_W     = 2 * ROW_W;
  localparam int MEM_DEPTH  = 1 << ADDR_W;
  // stack depth counter, holds 0..CELL_COUNT
  localparam int TOP_W      = ADDR_W + 1;
  localparam int SIDE_W     = 7;
  localparam int SIZE_W     = 13;

  // neighbor visit order
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // image cell word: {foreground, visited}
  localparam int CELL_FG  = 1;
  localparam int CELL_VIS = 0;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(64);

  // side register value -> side minus one, clamped to 1..MAX_SIDE
  function automatic logic [ROW_W-1:0] side_m1_of(input logic [SIDE_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MAX_SIDE) begin
      r = ROW_W'(MAX_SIDE - 1);
    end else begin
      r = ROW_W'(v - SIDE_W'(1));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/largest_blob_size_finder.sv
// ----------------------------------------------------------------------------
// largest_blob_size_finder
// Size of the largest 4-connected foreground region of a square binary image.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg channel (valid/ready) sets side_length (0 acts as 1, above 64 as 64)
//    and restarts the frame. Ready is high only while pixels are being taken.
//  - in channel (valid/stall) carries one pixel per transfer, row-major,
//    side*side transfers per frame. The last pixel starts the search.
//  - out channel (valid/stall) delivers one largest_size per frame.
// Operation:
//  - Loading: one pixel per cycle while cfg_valid is low.
//  - Search: each pixel is read and checked in turn; a new region is filled
//    by stack pops, each followed by a read and check of every in-bounds
//    neighbor, out-of-bounds directions being skipped. The pace is set by the
//    single read port of the image memory. The result is then posted.
//  - in_stall stays high from the last pixel until the result is posted.
// Reset: frame restarts, side becomes 64, no result pending. No clearing
// pass: each loaded pixel also clears its visited bit.
// Receiver stall: the result is held in the output register; the next frame
// loads meanwhile, and its search waits at the end for that register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "largest_blob_size_finder_defines.svh"

module largest_blob_size_finder
  import lbsf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIDE_W-1:0] cfg_side_length,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_pixel,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [SIZE_W-1:0]      out_largest_size
);

  typedef enum logic [2:0] {
    S_LOAD,      // taking pixels
    S_SCAN_RD,   // read image at scan position
    S_SCAN_CHK,  // seed a fill if unvisited foreground
    S_POP,       // pop stack or close region
    S_POP_WAIT,  // stack data returns
    S_NB_RD,     // read one neighbor
    S_NB_CHK,    // mark and push neighbor
    S_FIN        // post result
  } state_t;

  state_t state_r, state_nxt;

  logic [ROW_W-1:0]  side_m1_r, side_m1_nxt;
  logic [ROW_W-1:0]  ld_row_r, ld_row_nxt, ld_col_r, ld_col_nxt;
  logic [ROW_W-1:0]  sc_row_r, sc_row_nxt, sc_col_r, sc_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  nb_row_r, nb_row_nxt, nb_col_r, nb_col_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic [TOP_W-1:0]  top_r, top_nxt;
  logic [SIZE_W-1:0] count_r, count_nxt, best_r, best_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SIZE_W-1:0] out_size_r, out_size_nxt;

  // image memory: {foreground, visited} per cell
  logic [1:0]        img_mem [MEM_DEPTH];
  logic              img_we;
  logic [ADDR_W-1:0] img_waddr, img_raddr;
  logic [1:0]        img_wdata, img_rdata_r;

  // search stack memory of {row, col}
  logic [ADDR_W-1:0] stk_mem [MEM_DEPTH];
  logic              stk_we;
  logic [ADDR_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata_r;

  logic              in_xfer, cfg_xfer, ld_last, sc_last;
  logic              nb_ok;
  logic [ROW_W-1:0]  nb_row, nb_col;
  logic [TOP_W-1:0]  top_dec;

  assign cfg_ready        = (state_r == S_LOAD);
  assign in_stall         = (state_r != S_LOAD) || cfg_valid;
  assign out_valid        = out_valid_r;
  assign out_largest_size = out_size_r;

  assign cfg_xfer = cfg_valid && cfg_ready;
  assign in_xfer  = in_valid && !in_stall;
  assign ld_last  = (ld_row_r == side_m1_r) && (ld_col_r == side_m1_r);
  assign sc_last  = (sc_row_r == side_m1_r) && (sc_col_r == side_m1_r);
  assign top_dec  = top_r - TOP_W'(1);

  // neighbor of the current cell in direction dir_r, with bounds check
  always_comb begin
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    nb_ok  = 1'b0;
    unique case (dir_r)
      DIR_UP: begin
        nb_ok  = (cur_row_r != '0);
        nb_row = cur_row_r - ROW_W'(1);
      end
      DIR_DOWN: begin
        nb_ok  = (cur_row_r != side_m1_r);
        nb_row = cur_row_r + ROW_W'(1);
      end
      DIR_LEFT: begin
        nb_ok  = (cur_col_r != '0);
        nb_col = cur_col_r - ROW_W'(1);
      end
      DIR_RIGHT: begin
        nb_ok  = (cur_col_r != side_m1_r);
        nb_col = cur_col_r + ROW_W'(1);
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    side_m1_nxt   = side_m1_r;
    ld_row_nxt    = ld_row_r;
    ld_col_nxt    = ld_col_r;
    sc_row_nxt    = sc_row_r;
    sc_col_nxt    = sc_col_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    nb_row_nxt    = nb_row_r;
    nb_col_nxt    = nb_col_r;
    dir_nxt       = dir_r;
    top_nxt       = top_r;
    count_nxt     = count_r;
    best_nxt      = best_r;
    out_size_nxt  = out_size_r;
    out_valid_nxt = out_valid_r && out_stall;

    img_we    = 1'b0;
    img_waddr = {ld_row_r, ld_col_r};
    img_wdata = {in_pixel, 1'b0};
    img_raddr = {sc_row_r, sc_col_r};
    stk_we    = 1'b0;
    stk_waddr = top_r[ADDR_W-1:0];
    stk_wdata = {nb_row_r, nb_col_r};
    stk_raddr = top_dec[ADDR_W-1:0];

    unique case (state_r)
      S_LOAD: begin
        if (cfg_xfer) begin
          side_m1_nxt = side_m1_of(cfg_side_length);
          ld_row_nxt  = '0;
          ld_col_nxt  = '0;
        end else if (in_xfer) begin
          // store pixel, clear its visited bit
          img_we = 1'b1;
          if (ld_last) begin
            ld_row_nxt = '0;
            ld_col_nxt = '0;
            sc_row_nxt = '0;
            sc_col_nxt = '0;
            best_nxt   = '0;
            state_nxt  = S_SCAN_RD;
          end else if (ld_col_r == side_m1_r) begin
            ld_col_nxt = '0;
            ld_row_nxt = ld_row_r + ROW_W'(1);
          end else begin
            ld_col_nxt = ld_col_r + ROW_W'(1);
          end
        end
      end

      S_SCAN_RD: begin
        img_raddr = {sc_row_r, sc_col_r};
        state_nxt = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (img_rdata_r[CELL_FG] && !img_rdata_r[CELL_VIS]) begin
          // new region: mark seed and push it
          img_we    = 1'b1;
          img_waddr = {sc_row_r, sc_col_r};
          img_wdata = 2'b11;
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {sc_row_r, sc_col_r};
          top_nxt   = TOP_W'(1);
          count_nxt = '0;
          state_nxt = S_POP;
        end else if (sc_last) begin
          state_nxt = S_FIN;
        end else begin
          if (sc_col_r == side_m1_r) begin
            sc_col_nxt = '0;
            sc_row_nxt = sc_row_r + ROW_W'(1);
          end else begin
            sc_col_nxt = sc_col_r + ROW_W'(1);
          end
          state_nxt = S_SCAN_RD;
        end
      end

      S_POP: begin
        if (top_r == '0) begin
          // region closed
          if (count_r > best_r) best_nxt = count_r;
          if (sc_last) begin
            state_nxt = S_FIN;
          end else begin
            if (sc_col_r == side_m1_r) begin
              sc_col_nxt = '0;
              sc_row_nxt = sc_row_r + ROW_W'(1);
            end else begin
              sc_col_nxt = sc_col_r + ROW_W'(1);
            end
            state_nxt = S_SCAN_RD;
          end
        end else begin
          stk_raddr = top_dec[ADDR_W-1:0];
          top_nxt   = top_dec;
          state_nxt = S_POP_WAIT;
        end
      end

      S_POP_WAIT: begin
        cur_row_nxt = stk_rdata_r[ADDR_W-1:ROW_W];
        cur_col_nxt = stk_rdata_r[ROW_W-1:0];
        // saturating region count
        if (count_r != '1) count_nxt = count_r + SIZE_W'(1);
        dir_nxt   = DIR_UP;
        state_nxt = S_NB_RD;
      end

      S_NB_RD: begin
        if (nb_ok) begin
          img_raddr  = {nb_row, nb_col};
          nb_row_nxt = nb_row;
          nb_col_nxt = nb_col;
          state_nxt  = S_NB_CHK;
        end else if (dir_r == DIR_RIGHT) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end

      S_NB_CHK: begin
        if (img_rdata_r[CELL_FG] && !img_rdata_r[CELL_VIS]) begin
          img_we    = 1'b1;
          img_waddr = {nb_row_r, nb_col_r};
          img_wdata = 2'b11;
          stk_we    = 1'b1;
          stk_waddr = top_r[ADDR_W-1:0];
          stk_wdata = {nb_row_r, nb_col_r};
          top_nxt   = top_r + TOP_W'(1);
        end
        if (dir_r == DIR_RIGHT) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt   = dir_r + 2'd1;
          state_nxt = S_NB_RD;
        end
      end

      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_size_nxt  = best_r;
          state_nxt     = S_LOAD;
        end
      end

      default: state_nxt = S_LOAD;
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      side_m1_r   <= side_m1_of(SIDE_RESET);
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      sc_row_r    <= '0;
      sc_col_r    <= '0;
      dir_r       <= DIR_UP;
      top_r       <= '0;
      count_r     <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_m1_r   <= side_m1_nxt;
      ld_row_r    <= ld_row_nxt;
      ld_col_r    <= ld_col_nxt;
      sc_row_r    <= sc_row_nxt;
      sc_col_r    <= sc_col_nxt;
      dir_r       <= dir_nxt;
      top_r       <= top_nxt;
      count_r     <= count_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    nb_row_r   <= nb_row_nxt;
    nb_col_r   <= nb_col_nxt;
    out_size_r <= out_size_nxt;
  end

  // image memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (img_we) img_mem[img_waddr] <= img_wdata;
    img_rdata_r <= img_mem[img_raddr];
  end

  // stack memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rdata_r <= stk_mem[stk_raddr];
  end

  // assertions
  `LBSF_ASSERT_IMP(a_top_bound, 1'b1, 32'(top_r) <= CELL_COUNT,
                   "search stack overflow")
  `LBSF_ASSERT_IMP(a_region_nonempty, (state_r == S_POP) && (top_r == '0),
                   count_r != '0, "closed region with zero size")
  `LBSF_ASSERT_NXT(a_last_starts_scan, in_xfer && ld_last,
                   (state_r == S_SCAN_RD) && (best_r == '0),
                   "last pixel did not start the scan")

endmodule

`default_nettype wire
